>>> hw/rtl/mspan_pkg.sv
// shared types, register codes and constants for the mono span fill block
`timescale 1ns / 1ps
`default_nettype none

package mspan_pkg;

    // default line length in pixels
    localparam int LINE_PIXELS_DEF = 512;

    // field and register widths
    localparam int IN_W   = 14;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;
    localparam int ROW_W  = 13;
    localparam int CLIP_W = 10;
    localparam int ADDR_W = 32;
    localparam int PROD_W = 2 * ROW_W;

    localparam logic [7:0] C_FULL_MASK = 8'hFF;

    // register indexes
    localparam logic [IDX_W-1:0] REG_FG_COLOR     = 3'd0;
    localparam logic [IDX_W-1:0] REG_BASE_ADDRESS = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW_STRIDE   = 3'd2;
    localparam logic [IDX_W-1:0] REG_CLIP_LEFT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CLIP_RIGHT   = 3'd4;
    localparam logic [IDX_W-1:0] REG_CLIP_TOP     = 3'd5;
    localparam logic [IDX_W-1:0] REG_CLIP_BOTTOM  = 3'd6;

    typedef struct packed {
        logic              fg_color;
        logic [ADDR_W-1:0] base_address;
        logic [ROW_W-1:0]  row_stride;
        logic [CLIP_W-1:0] clip_left;
        logic [CLIP_W-1:0] clip_right;
        logic [ROW_W-1:0]  clip_top;
        logic [ROW_W-1:0]  clip_bottom;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic add_row;
        logic step;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic at_last;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hw/rtl/mspan_ctrl.sv
// sequencing state machine for the mono span fill block
`timescale 1ns / 1ps
`default_nettype none

module mspan_ctrl
    import mspan_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_dp_stat i_stat,
    output logic          busy,
    output t_dp_cmd       o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROW  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ROW;
                end
            end
            S_ROW: begin
                o_cmd.add_row = 1'b1;
                n_state       = i_stat.empty ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                o_cmd.step = 1'b1;
                if (i_stat.at_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/mspan_dp.sv
// clipping, row address and byte write datapath for the mono span fill block
`timescale 1ns / 1ps
`default_nettype none

module mspan_dp
    import mspan_pkg::*;
#(
    parameter int LINE_PIXELS = LINE_PIXELS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    input  wire t_cfg                     i_cfg,
    input  wire logic signed [IN_W-1:0]   i_span_x,
    input  wire logic signed [IN_W-1:0]   i_span_y,
    input  wire logic signed [IN_W-1:0]   i_span_width,
    output t_dp_stat                      o_stat,
    output logic                          o_valid,
    output logic [ADDR_W-1:0]             o_byte_address,
    output logic [7:0]                    o_write_data,
    output logic [7:0]                    o_write_mask,
    output logic                          o_last_write
);

    localparam int COL_W  = $clog2(LINE_PIXELS + 1);
    localparam int BYTE_W = COL_W - 3;
    localparam int SUM_W  = IN_W + 2;
    localparam logic [CLIP_W-1:0] EDGE_MAX = CLIP_W'(LINE_PIXELS);

    // clip arithmetic
    logic [CLIP_W-1:0]       left_lim;
    logic [CLIP_W-1:0]       right_lim;
    logic signed [SUM_W-1:0] x_s;
    logic signed [SUM_W-1:0] y_s;
    logic signed [SUM_W-1:0] w_s;
    logic signed [SUM_W-1:0] left_s;
    logic signed [SUM_W-1:0] right_s;
    logic signed [SUM_W-1:0] top_s;
    logic signed [SUM_W-1:0] bot_s;
    logic signed [SUM_W-1:0] start_s;
    logic signed [SUM_W-1:0] sum_s;
    logic signed [SUM_W-1:0] end_s;
    logic signed [SUM_W-1:0] endm1_s;
    logic                    row_ok;
    logic                    empty_c;
    logic [PROD_W-1:0]       prod_c;

    // per span registers
    logic                r_empty;
    logic [PROD_W-1:0]   r_prod;
    logic [ADDR_W-1:0]   r_row_addr;
    logic [BYTE_W-1:0]   r_cur;
    logic [BYTE_W-1:0]   r_last;
    logic [2:0]          r_x3;
    logic [2:0]          r_e3;
    logic                r_first;

    // output registers
    logic                r_valid;
    logic [ADDR_W-1:0]   r_addr;
    logic [7:0]          r_data;
    logic [7:0]          r_mask;
    logic                r_last_wr;

    logic [7:0] front_mask;
    logic [7:0] back_mask;
    logic [7:0] mask_c;
    logic       at_last;

    always_comb begin
        left_lim  = (i_cfg.clip_left > EDGE_MAX) ? EDGE_MAX : i_cfg.clip_left;
        right_lim = (i_cfg.clip_right > EDGE_MAX) ? EDGE_MAX : i_cfg.clip_right;
        x_s       = SUM_W'(i_span_x);
        y_s       = SUM_W'(i_span_y);
        w_s       = SUM_W'(i_span_width);
        left_s    = $signed({{(SUM_W-CLIP_W){1'b0}}, left_lim});
        right_s   = $signed({{(SUM_W-CLIP_W){1'b0}}, right_lim});
        top_s     = $signed({{(SUM_W-ROW_W){1'b0}}, i_cfg.clip_top});
        bot_s     = $signed({{(SUM_W-ROW_W){1'b0}}, i_cfg.clip_bottom});
        start_s   = (x_s > left_s) ? x_s : left_s;
        sum_s     = x_s + w_s;
        end_s     = (sum_s < right_s) ? sum_s : right_s;
        endm1_s   = end_s - SUM_W'(1);
        row_ok    = (y_s >= top_s) && (y_s < bot_s);
        empty_c   = !row_ok || (end_s <= start_s);
        // y is within 0..8191 whenever the row is visible
        prod_c    = PROD_W'(i_span_y[ROW_W-1:0]) * PROD_W'(i_cfg.row_stride);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_empty <= empty_c;
            r_prod  <= prod_c;
            r_x3    <= start_s[2:0];
            r_e3    <= endm1_s[2:0];
            r_cur   <= start_s[COL_W-1:3];
            r_last  <= endm1_s[COL_W-1:3];
            r_first <= 1'b1;
        end
        if (i_cmd.add_row) begin
            r_row_addr <= i_cfg.base_address + ADDR_W'(r_prod);
        end
        if (i_cmd.step) begin
            r_cur     <= r_cur + BYTE_W'(1);
            r_first   <= 1'b0;
            r_addr    <= r_row_addr + ADDR_W'(r_cur);
            r_data    <= {8{i_cfg.fg_color}} & mask_c;
            r_mask    <= mask_c;
            r_last_wr <= at_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.step;
        end
    end

    always_comb begin
        at_last    = (r_cur == r_last);
        front_mask = r_first ? 8'(C_FULL_MASK >> r_x3) : C_FULL_MASK;
        back_mask  = at_last ? 8'(C_FULL_MASK << (3'd7 - r_e3)) : C_FULL_MASK;
        mask_c     = front_mask & back_mask;
    end

    assign o_stat.empty   = r_empty;
    assign o_stat.at_last = at_last;
    assign o_valid        = r_valid;
    assign o_byte_address = r_addr;
    assign o_write_data   = r_data;
    assign o_write_mask   = r_mask;
    assign o_last_write   = r_last_wr;

endmodule

`default_nettype wire

>>> hw/rtl/mono_span_fill.sv
// top level of the clipped 1bpp horizontal span fill block
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  -----------------------------------------
//  span      in         start high, busy low      i_span_x, i_span_y, i_span_width
//  write     out        o_valid, one cycle        o_byte_address, o_write_data,
//                                                 o_write_mask, o_last_write
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
//  a span transaction keeps the block busy while it emits one write per byte touched (1..64),
//  and returns it to idle without writes when it clips away to nothing
//  the first write shows after the row address state and the first emit step, then one write per cycle:
//  the byte cursor and the single output register set the pace
//  reset (synchronous, active low) returns the sequencer to idle and loads register defaults
//  the write receiver cannot stall, so writes stream out back to back
`timescale 1ns / 1ps
`default_nettype none

module mono_span_fill
    import mspan_pkg::*;
#(
    parameter int LINE_PIXELS = LINE_PIXELS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // span transaction
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic signed [IN_W-1:0] i_span_x,
    input  wire logic signed [IN_W-1:0] i_span_y,
    input  wire logic signed [IN_W-1:0] i_span_width,
    // byte write transaction
    output logic                        o_valid,
    output logic [ADDR_W-1:0]           o_byte_address,
    output logic [7:0]                  o_write_data,
    output logic [7:0]                  o_write_mask,
    output logic                        o_last_write,
    // register writes
    input  wire logic                   i_cfg_we,
    input  wire logic [IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data
);

    t_cfg     r_cfg;
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     start_ok;

    // register bank, an index beyond the list is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fg_color     <= 1'b1;
            r_cfg.base_address <= '0;
            r_cfg.row_stride   <= ROW_W'(64);
            r_cfg.clip_left    <= '0;
            r_cfg.clip_right   <= CLIP_W'(512);
            r_cfg.clip_top     <= '0;
            r_cfg.clip_bottom  <= ROW_W'(4096);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FG_COLOR:     r_cfg.fg_color     <= i_cfg_data[0];
                REG_BASE_ADDRESS: r_cfg.base_address <= i_cfg_data[ADDR_W-1:0];
                REG_ROW_STRIDE:   r_cfg.row_stride   <= i_cfg_data[ROW_W-1:0];
                REG_CLIP_LEFT:    r_cfg.clip_left    <= i_cfg_data[CLIP_W-1:0];
                REG_CLIP_RIGHT:   r_cfg.clip_right   <= i_cfg_data[CLIP_W-1:0];
                REG_CLIP_TOP:     r_cfg.clip_top     <= i_cfg_data[ROW_W-1:0];
                REG_CLIP_BOTTOM:  r_cfg.clip_bottom  <= i_cfg_data[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer: idle, row address, byte emission
    mspan_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .busy    (busy),
        .o_cmd   (dp_cmd)
    );

    // clip, row multiply and masked byte generation
    mspan_dp #(
        .LINE_PIXELS (LINE_PIXELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_cfg          (r_cfg),
        .i_span_x       (i_span_x),
        .i_span_y       (i_span_y),
        .i_span_width   (i_span_width),
        .o_stat         (dp_stat),
        .o_valid        (o_valid),
        .o_byte_address (o_byte_address),
        .o_write_data   (o_write_data),
        .o_write_mask   (o_write_mask),
        .o_last_write   (o_last_write)
    );

    assign start_ok = start && !busy;

    // an accepted span always occupies the sequencer for the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_ok |=> busy)
        else $error("accepted span did not make the block busy");

    // a write never carries an empty mask
    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_write_mask != 8'h00))
        else $error("write with empty mask");

    // colour bits stay inside the mask
    a_data_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_write_data & ~o_write_mask) == 8'h00))
        else $error("write data outside mask");

    // the last write of a span is followed by a gap before the next span's writes
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_write) |=> !o_valid)
        else $error("write straight after the last write of a span");

endmodule

`default_nettype wire
